FILE: design/cdq_pkg.sv
package cdq_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch request, start ring read
    logic commit;   // update pointers, write ring, load result register
  } cdq_cmd_t;

endpackage

FILE: design/cdq_if.sv
interface cdq_req_if;
  import cdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface cdq_rsp_if;
  import cdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     status;
  logic signed [DATA_W-1:0] popped_value;
  logic                     is_full;
  logic                     is_empty;

  modport source (output valid, output status, output popped_value, output is_full,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input popped_value, input is_full,
                  input is_empty, output ready);
endinterface

FILE: design/cdq_ctrl.sv
module cdq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cdq_pkg::cdq_cmd_t cmd_o
);
  import cdq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.commit = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/cdq_datapath.sv
module cdq_datapath #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cdq_pkg::cdq_cmd_t                cmd_i,
  input  logic [cdq_pkg::OP_W-1:0]         operation_i,
  input  logic signed [cdq_pkg::DATA_W-1:0] push_value_i,
  output logic                             status_o,
  output logic signed [cdq_pkg::DATA_W-1:0] popped_value_o,
  output logic                             is_full_o,
  output logic                             is_empty_o
);
  import cdq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [DATA_W-1:0] ring_mem [DEPTH];

  logic [AW-1:0]     head_q, head_d, tail_q, tail_d;
  logic              empty_q, empty_d;
  op_e               op_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] rd_q;

  logic              status_q;
  logic [DATA_W-1:0] popped_q;
  logic              full_out_q, empty_out_q;

  logic [AW-1:0]     head_nx, head_pv, tail_nx, tail_pv, tail_d_nx, rd_addr, wr_addr;
  logic              full_now, full_after, is_push, refused, wr_en;
  logic [DATA_W-1:0] popped;

  assign head_nx   = (head_q == LAST) ? '0 : head_q + 1'b1;
  assign head_pv   = (head_q == '0) ? LAST : head_q - 1'b1;
  assign tail_nx   = (tail_q == LAST) ? '0 : tail_q + 1'b1;
  assign tail_pv   = (tail_q == '0) ? LAST : tail_q - 1'b1;
  assign tail_d_nx = (tail_d == LAST) ? '0 : tail_d + 1'b1;

  assign full_now   = !empty_q && (tail_nx == head_q);
  assign full_after = !empty_d && (tail_d_nx == head_d);
  assign is_push    = (op_q == OP_PUSH_REAR) || (op_q == OP_PUSH_FRONT);
  assign rd_addr    = (op_e'(operation_i) == OP_POP_FRONT) ? head_q : tail_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    refused = 1'b0;
    wr_en   = 1'b0;
    wr_addr = tail_nx;
    popped  = '0;
    if (is_push) begin
      if (full_now) begin
        refused = 1'b1;
      end else if (empty_q) begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b0;
        wr_en   = 1'b1;
        wr_addr = '0;
      end else if (op_q == OP_PUSH_REAR) begin
        tail_d  = tail_nx;
        wr_en   = 1'b1;
        wr_addr = tail_nx;
      end else begin
        head_d  = head_pv;
        wr_en   = 1'b1;
        wr_addr = head_pv;
      end
    end else begin
      if (empty_q) begin
        refused = 1'b1;
      end else begin
        popped = rd_q;
        if (head_q == tail_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b1;
        end else if (op_q == OP_POP_FRONT) begin
          head_d = head_nx;
        end else begin
          tail_d = tail_pv;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) ring_mem[wr_addr] <= val_q;
    if (cmd_i.capture) rd_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(operation_i);
      val_q <= push_value_i;
    end
    if (cmd_i.commit) begin
      status_q    <= refused;
      popped_q    <= popped;
      full_out_q  <= full_after;
      empty_out_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else if (cmd_i.commit) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign is_full_o      = full_out_q;
  assign is_empty_o     = empty_out_q;

endmodule

FILE: design/circular_deque.sv
// Double-ended queue of signed 32-bit words in a ring of DEPTH entries. Each
// request pushes at the rear or front or pops from the front or rear; a push
// into a full ring or a pop from an empty ring is refused (status 1) and
// changes nothing. The ring memory read is registered in the accept cycle, and
// the pointer update, ring write and result capture follow in the execute
// state, once the output register is free. The result sits in an output
// register, so the next request is accepted while it waits; a new result is
// held back only until the previous one has been taken. The ring needs no
// clearing after reset: an entry is only read after it was written.
module circular_deque #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
  input logic  clk_i,
  input logic  rst_ni,
  cdq_req_if.sink   req_i,
  cdq_rsp_if.source rsp_o
);
  import cdq_pkg::*;

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (req_i.operation),
    .push_value_i   (req_i.push_value),
    .status_o       (rsp_o.status),
    .popped_value_o (rsp_o.popped_value),
    .is_full_o      (rsp_o.is_full),
    .is_empty_o     (rsp_o.is_empty)
  );

endmodule

FILE: design/cdq_checker.sv
module cdq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic                              rsp_status_i,
  input logic signed [cdq_pkg::DATA_W-1:0] rsp_popped_value_i,
  input logic                              rsp_is_full_i,
  input logic                              rsp_is_empty_i
);
  import cdq_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_popped_value_i)
      && $stable(rsp_status_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_is_full_i && rsp_is_empty_i))
    else $error("ring reported full and empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i |-> rsp_popped_value_i == '0)
    else $error("refused request returned a word");

  // a fresh result follows an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_valid_i && req_ready_i, 2))
    else $error("result without request");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.status),
  .rsp_popped_value_i (rsp_o.popped_value),
  .rsp_is_full_i      (rsp_o.is_full),
  .rsp_is_empty_i     (rsp_o.is_empty)
);

FILE: verif/tb.sv
module tb;
  import cdq_pkg::*;

  localparam int unsigned RING_DEPTH = DEPTH_DEF;
  localparam int unsigned N_RAND     = 1800;
  localparam int unsigned N_CALM     = 200;
  localparam int unsigned STALL_MAX  = 1000;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] popped;
    logic                     full;
    logic                     empty;
  } deque_rsp_t;

  typedef struct {
    op_e                      op;
    logic signed [DATA_W-1:0] word;
    int unsigned              reps;
    bit                       typed;
    deque_rsp_t               want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  cdq_req_if req ();
  cdq_rsp_if rsp ();

  circular_deque #(.DEPTH(RING_DEPTH)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // model of the ring
  logic signed [DATA_W-1:0] ring [RING_DEPTH];
  int unsigned              head_pos;
  int unsigned              tail_pos;
  bit                       ring_empty;

  deque_rsp_t pending_results [$];
  deque_rsp_t typed_rsp;
  bit         typed_on;
  deque_rsp_t predicted;
  deque_rsp_t seen;
  deque_rsp_t want;
  int unsigned errors;
  int unsigned quiet_cycles;
  bit         calm;

  // quick fill, full/empty refusals, extremes, wrap at both ends
  dir_row_t dir_tbl [15] = '{
    '{OP_POP_FRONT,  32'sh0,        1,  1'b1, '{1'b1, 32'sh0,        1'b0, 1'b1}},
    '{OP_POP_REAR,   32'sh0,        1,  1'b1, '{1'b1, 32'sh0,        1'b0, 1'b1}},
    '{OP_PUSH_REAR,  32'sh7fffffff, 1,  1'b1, '{1'b0, 32'sh0,        1'b0, 1'b0}},
    '{OP_POP_FRONT,  32'sh0,        1,  1'b1, '{1'b0, 32'sh7fffffff, 1'b0, 1'b1}},
    '{OP_PUSH_FRONT, 32'sh80000000, 1,  1'b1, '{1'b0, 32'sh0,        1'b0, 1'b0}},
    '{OP_POP_REAR,   32'shffffffff, 1,  1'b1, '{1'b0, 32'sh80000000, 1'b0, 1'b1}},
    '{OP_PUSH_FRONT, 32'shffffffff, 1,  1'b0, '0},
    '{OP_PUSH_REAR,  32'sh0,        1,  1'b0, '0},
    '{OP_PUSH_REAR,  32'sh55555555, 14, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'sh1,        1,  1'b1, '{1'b1, 32'sh0,        1'b1, 1'b0}},
    '{OP_PUSH_REAR,  32'shaaaaaaaa, 1,  1'b1, '{1'b1, 32'sh0,        1'b1, 1'b0}},
    '{OP_POP_FRONT,  32'sh0,        1,  1'b0, '0},
    '{OP_PUSH_REAR,  32'shaaaaaaaa, 1,  1'b0, '0},
    '{OP_POP_REAR,   32'sh0,        16, 1'b0, '0},
    '{OP_POP_FRONT,  32'sh0,        1,  1'b1, '{1'b1, 32'sh0,        1'b0, 1'b1}}
  };

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic bit ring_full();
    return !ring_empty && ((tail_pos + 1) % RING_DEPTH == head_pos);
  endfunction

  function automatic deque_rsp_t deque_step(op_e op, logic signed [DATA_W-1:0] word);
    deque_rsp_t r;
    int unsigned pos;
    r = '0;
    if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT) begin
      if (ring_full()) begin
        r.status = 1'b1;
      end else if (ring_empty) begin
        head_pos   = 0;
        tail_pos   = 0;
        ring_empty = 1'b0;
        ring[0]    = word;
      end else if (op == OP_PUSH_REAR) begin
        tail_pos       = (tail_pos + 1) % RING_DEPTH;
        ring[tail_pos] = word;
      end else begin
        head_pos       = (head_pos + RING_DEPTH - 1) % RING_DEPTH;
        ring[head_pos] = word;
      end
    end else if (ring_empty) begin
      r.status = 1'b1;
    end else begin
      pos      = (op == OP_POP_FRONT) ? head_pos : tail_pos;
      r.popped = ring[pos];
      if (head_pos == tail_pos) begin
        head_pos   = 0;
        tail_pos   = 0;
        ring_empty = 1'b1;
      end else if (op == OP_POP_FRONT) begin
        head_pos = (head_pos + 1) % RING_DEPTH;
      end else begin
        tail_pos = (tail_pos + RING_DEPTH - 1) % RING_DEPTH;
      end
    end
    r.full  = ring_full();
    r.empty = ring_empty;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // predict on accept, check on response, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (req.valid && req.ready) begin
        quiet_cycles = 0;
        predicted = deque_step(op_e'(req.operation), req.push_value);
        pending_results.push_back(typed_on ? typed_rsp : predicted);
      end
      if (rsp.valid && rsp.ready) begin
        quiet_cycles = 0;
        seen = '{rsp.status, rsp.popped_value, rsp.is_full, rsp.is_empty};
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = pending_results.pop_front();
          if (seen.status !== want.status)
            report_mismatch($sformatf("status %b, want %b", seen.status, want.status));
          if (seen.popped !== want.popped)
            report_mismatch($sformatf("popped_value %h, want %h", seen.popped, want.popped));
          if (seen.full !== want.full)
            report_mismatch($sformatf("is_full %b, want %b", seen.full, want.full));
          if (seen.empty !== want.empty)
            report_mismatch($sformatf("is_empty %b, want %b", seen.empty, want.empty));
        end
      end
      if (quiet_cycles >= STALL_MAX) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result-side backpressure
  initial begin
    rsp.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 11) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        rsp.ready <= 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk_i);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_req(op_e op, logic signed [DATA_W-1:0] word, bit typed, deque_rsp_t exp_rsp);
    typed_on          = typed;
    typed_rsp         = exp_rsp;
    req.valid        <= 1'b1;
    req.operation    <= op;
    req.push_value   <= word;
    do @(posedge clk_i); while (!(req.valid && req.ready));
    @(negedge clk_i);
  endtask

  task automatic idle_burst();
    req.valid <= 1'b0;
    repeat ($urandom_range(1, 13)) @(negedge clk_i);
  endtask

  task automatic drain_wait();
    req.valid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return -32'sd1;
      3:       return 32'sh0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned seg_len;
    int unsigned mode;
    int unsigned push_pct;
    op_e         op;

    rst_ni         = 1'b0;
    req.valid      = 1'b0;
    req.operation  = OP_PUSH_REAR;
    req.push_value = '0;
    typed_on       = 1'b0;
    typed_rsp      = '0;
    errors         = 0;
    quiet_cycles   = 0;
    calm           = 1'b0;
    head_pos       = 0;
    tail_pos       = 0;
    ring_empty     = 1'b1;
    foreach (ring[i]) ring[i] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tbl[i]) begin
      for (int unsigned k = 0; k < dir_tbl[i].reps; k++)
        send_req(dir_tbl[i].op, dir_tbl[i].word, dir_tbl[i].typed, dir_tbl[i].want);
    end
    drain_wait();

    // segments biased to fill, drain or hover so full and empty come often
    sent = 0;
    while (sent < N_RAND) begin
      seg_len = $urandom_range(8, 64);
      mode    = $urandom_range(0, 2);
      push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      if (!calm && $urandom_range(0, 5) == 0) drain_wait();
      for (int unsigned k = 0; k < seg_len && sent < N_RAND; k++) begin
        calm = (sent >= N_RAND - N_CALM);
        if ($urandom_range(1, 100) <= push_pct)
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        else
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
        if (!calm && $urandom_range(0, 9) == 0) idle_burst();
        send_req(op, rand_word(), 1'b0, '0);
        sent++;
      end
    end

    calm = 1'b1;
    drain_wait();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: circular_deque.f
design/cdq_pkg.sv
design/cdq_if.sv
design/cdq_ctrl.sv
design/cdq_datapath.sv
design/circular_deque.sv
design/cdq_checker.sv
verif/tb.sv
